// ===== sv/particle_wall_bounce_core_defines.svh =====
// Assertion macros for the particle wall bounce core.
// Used by particle_wall_bounce_core.sv; expects clk and rst_n in scope.
`ifndef PARTICLE_WALL_BOUNCE_CORE_DEFINES_SVH
`define PARTICLE_WALL_BOUNCE_CORE_DEFINES_SVH

// Same-cycle implication, disabled in reset
`define PWB_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled in reset
`define PWB_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/pwb_pkg.sv =====
// Package for the particle wall bounce core: register indexes, reset values,
// field widths and the saturation / reflection helpers. No dependencies.
`default_nettype none

package pwb_pkg;

  localparam int unsigned NUM_AXES  = 3;
  localparam int unsigned DATA_W    = 32;
  localparam int unsigned RAD_W     = 31;
  localparam int unsigned REST_W    = 16;
  localparam int unsigned HITS_W    = 2 * NUM_AXES;
  localparam int unsigned PROD_W    = REST_W + 1 + DATA_W;  // signed product
  localparam int unsigned FRAC_BITS = 15;                   // Q1.15 restitution

  localparam logic signed [DATA_W-1:0] LOW_WALL_RST  = -32'sd655360;
  localparam logic signed [DATA_W-1:0] HIGH_WALL_RST = 32'sd655360;
  localparam logic [REST_W-1:0]        REST_RST      = 16'd32768;

  // Configuration register indexes
  typedef enum logic [2:0] {
    CFG_X_LOW_WALL   = 3'd0,
    CFG_X_HIGH_WALL  = 3'd1,
    CFG_Y_LOW_WALL   = 3'd2,
    CFG_Y_HIGH_WALL  = 3'd3,
    CFG_Z_LOW_WALL   = 3'd4,
    CFG_Z_HIGH_WALL  = 3'd5,
    CFG_RESTITUTION  = 3'd6
  } cfg_reg_t;

  typedef logic signed [DATA_W-1:0] word_t;
  typedef logic signed [PROD_W-1:0] prod_t;

  // Clamp a 35-bit signed value into the signed 32-bit range
  function automatic word_t sat32(input logic signed [34:0] v);
    word_t res;
    if (v > 35'sh7FFF_FFFF) begin
      res = 32'sh7FFF_FFFF;
    end else if (v < -35'sh8000_0000) begin
      res = -32'sh8000_0000;
    end else begin
      res = v[DATA_W-1:0];
    end
    return res;
  endfunction

  // Finish a reflection: floor shift of the product, negate, saturate
  function automatic word_t reflect_finish(input prod_t prod);
    logic signed [PROD_W-FRAC_BITS-1:0] q;
    logic signed [34:0]                 neg;
    q   = prod[PROD_W-1:FRAC_BITS];
    neg = -(35'(q));
    return sat32(neg);
  endfunction

endpackage

`default_nettype wire

// ===== sv/particle_wall_bounce_core.sv =====
// Particle wall bounce core: five-stage pipeline from an accepted input transaction
// to its result on the out_ ports. Throughput one transaction per clock unless
// the pipeline is frozen; the two restitution multipliers sit in stages two and
// four, each followed by a register. A stalled output holding a valid result
// freezes the whole pipeline. Synchronous active-low reset clears the stage valid
// bits and loads the walls to -10.0 / +10.0 and restitution to 1.0.
`default_nettype none
`include "particle_wall_bounce_core_defines.svh"

module particle_wall_bounce_core
  import pwb_pkg::*;
(
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  // configuration write port
  input  wire logic                     cfg_we,
  input  wire logic [2:0]               cfg_index,
  input  wire logic [DATA_W-1:0]        cfg_data,
  // input channel
  input  wire logic                     in_valid,
  output logic                          in_stall,
  input  wire logic signed [DATA_W-1:0] in_pos_x,
  input  wire logic signed [DATA_W-1:0] in_pos_y,
  input  wire logic signed [DATA_W-1:0] in_pos_z,
  input  wire logic signed [DATA_W-1:0] in_vel_x,
  input  wire logic signed [DATA_W-1:0] in_vel_y,
  input  wire logic signed [DATA_W-1:0] in_vel_z,
  input  wire logic [RAD_W-1:0]         in_radius,
  // result channel
  output logic                          out_valid,
  input  wire logic                     out_stall,
  output logic signed [DATA_W-1:0]      out_new_pos_x,
  output logic signed [DATA_W-1:0]      out_new_pos_y,
  output logic signed [DATA_W-1:0]      out_new_pos_z,
  output logic signed [DATA_W-1:0]      out_new_vel_x,
  output logic signed [DATA_W-1:0]      out_new_vel_y,
  output logic signed [DATA_W-1:0]      out_new_vel_z,
  output logic [HITS_W-1:0]             out_wall_hits
);

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  word_t             low_wall_r  [NUM_AXES];
  word_t             high_wall_r [NUM_AXES];
  logic [REST_W-1:0] rest_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int a = 0; a < NUM_AXES; a++) begin
        low_wall_r[a]  <= LOW_WALL_RST;
        high_wall_r[a] <= HIGH_WALL_RST;
      end
      rest_r <= REST_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_X_LOW_WALL:  low_wall_r[0]  <= cfg_data;
        CFG_X_HIGH_WALL: high_wall_r[0] <= cfg_data;
        CFG_Y_LOW_WALL:  low_wall_r[1]  <= cfg_data;
        CFG_Y_HIGH_WALL: high_wall_r[1] <= cfg_data;
        CFG_Z_LOW_WALL:  low_wall_r[2]  <= cfg_data;
        CFG_Z_HIGH_WALL: high_wall_r[2] <= cfg_data;
        CFG_RESTITUTION: rest_r         <= cfg_data[REST_W-1:0];
        default: ;  // unknown index: ignored
      endcase
    end
  end

  // Signed view of restitution for the multipliers
  logic signed [REST_W:0] rest_s;
  assign rest_s = $signed({1'b0, rest_r});

  // ---------------------------------------------------------------------------
  // Pipeline control: the output register holding a stalled result freezes all
  // ---------------------------------------------------------------------------
  logic pipe_en;
  logic a_valid_r, b_valid_r, c_valid_r, d_valid_r, e_valid_r;

  assign pipe_en  = !(e_valid_r && out_stall);
  assign in_stall = !pipe_en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
      b_valid_r <= 1'b0;
      c_valid_r <= 1'b0;
      d_valid_r <= 1'b0;
      e_valid_r <= 1'b0;
    end else if (pipe_en) begin
      a_valid_r <= in_valid;
      b_valid_r <= a_valid_r;
      c_valid_r <= b_valid_r;
      d_valid_r <= c_valid_r;
      e_valid_r <= d_valid_r;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage A: wall tests and snapped positions
  // ---------------------------------------------------------------------------
  word_t             in_pos [NUM_AXES];
  word_t             in_vel [NUM_AXES];
  word_t             a_pos_nxt [NUM_AXES];
  logic [HITS_W-1:0] a_hits_nxt;

  assign in_pos[0] = in_pos_x;
  assign in_pos[1] = in_pos_y;
  assign in_pos[2] = in_pos_z;
  assign in_vel[0] = in_vel_x;
  assign in_vel[1] = in_vel_y;
  assign in_vel[2] = in_vel_z;

  always_comb begin
    logic signed [DATA_W:0] rad_e;
    logic signed [DATA_W:0] pos_e;
    logic signed [DATA_W:0] lo_e;
    logic signed [DATA_W:0] hi_e;
    logic signed [DATA_W:0] near_lo;
    logic signed [DATA_W:0] near_hi;
    logic signed [DATA_W:0] snap_lo;
    logic signed [DATA_W:0] snap_hi;
    logic                   lo_hit;
    logic                   hi_hit;
    a_hits_nxt = '0;
    rad_e = $signed({2'b00, in_radius});
    for (int a = 0; a < NUM_AXES; a++) begin
      pos_e   = {in_pos[a][DATA_W-1], in_pos[a]};
      lo_e    = {low_wall_r[a][DATA_W-1], low_wall_r[a]};
      hi_e    = {high_wall_r[a][DATA_W-1], high_wall_r[a]};
      near_lo = pos_e - rad_e;
      near_hi = pos_e + rad_e;
      snap_lo = lo_e + rad_e;
      snap_hi = hi_e - rad_e;
      lo_hit  = (near_lo <= lo_e);
      hi_hit  = (near_hi >= hi_e);
      a_hits_nxt[2*a]   = lo_hit;
      a_hits_nxt[2*a+1] = hi_hit;
      // high wall wins for the position
      if (hi_hit) begin
        a_pos_nxt[a] = sat32({{2{snap_hi[DATA_W]}}, snap_hi});
      end else if (lo_hit) begin
        a_pos_nxt[a] = sat32({{2{snap_lo[DATA_W]}}, snap_lo});
      end else begin
        a_pos_nxt[a] = in_pos[a];
      end
    end
  end

  word_t             a_pos_r [NUM_AXES];
  word_t             a_vel_r [NUM_AXES];
  logic [HITS_W-1:0] a_hits_r;

  always_ff @(posedge clk) begin
    if (pipe_en) begin
      for (int a = 0; a < NUM_AXES; a++) begin
        a_pos_r[a] <= a_pos_nxt[a];
        a_vel_r[a] <= in_vel[a];
      end
      a_hits_r <= a_hits_nxt;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage B: first restitution product
  // ---------------------------------------------------------------------------
  word_t             b_pos_r  [NUM_AXES];
  word_t             b_vel_r  [NUM_AXES];
  prod_t             b_prod_r [NUM_AXES];
  logic [HITS_W-1:0] b_hits_r;

  always_ff @(posedge clk) begin
    if (pipe_en) begin
      for (int a = 0; a < NUM_AXES; a++) begin
        b_pos_r[a]  <= a_pos_r[a];
        b_vel_r[a]  <= a_vel_r[a];
        b_prod_r[a] <= rest_s * a_vel_r[a];
      end
      b_hits_r <= a_hits_r;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage C: low-wall reflection (floor, negate, saturate)
  // ---------------------------------------------------------------------------
  word_t c_vel_nxt [NUM_AXES];

  always_comb begin
    for (int a = 0; a < NUM_AXES; a++) begin
      c_vel_nxt[a] = b_hits_r[2*a] ? reflect_finish(b_prod_r[a]) : b_vel_r[a];
    end
  end

  word_t             c_pos_r [NUM_AXES];
  word_t             c_vel_r [NUM_AXES];
  logic [HITS_W-1:0] c_hits_r;

  always_ff @(posedge clk) begin
    if (pipe_en) begin
      for (int a = 0; a < NUM_AXES; a++) begin
        c_pos_r[a] <= b_pos_r[a];
        c_vel_r[a] <= c_vel_nxt[a];
      end
      c_hits_r <= b_hits_r;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage D: second restitution product, on the stage C velocity, the input or the saturated first result
  // ---------------------------------------------------------------------------
  word_t             d_pos_r  [NUM_AXES];
  word_t             d_vel_r  [NUM_AXES];
  prod_t             d_prod_r [NUM_AXES];
  logic [HITS_W-1:0] d_hits_r;

  always_ff @(posedge clk) begin
    if (pipe_en) begin
      for (int a = 0; a < NUM_AXES; a++) begin
        d_pos_r[a]  <= c_pos_r[a];
        d_vel_r[a]  <= c_vel_r[a];
        d_prod_r[a] <= rest_s * c_vel_r[a];
      end
      d_hits_r <= c_hits_r;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage E: high-wall reflection into the output register
  // ---------------------------------------------------------------------------
  word_t e_vel_nxt [NUM_AXES];

  always_comb begin
    for (int a = 0; a < NUM_AXES; a++) begin
      e_vel_nxt[a] = d_hits_r[2*a+1] ? reflect_finish(d_prod_r[a]) : d_vel_r[a];
    end
  end

  word_t             e_pos_r [NUM_AXES];
  word_t             e_vel_r [NUM_AXES];
  logic [HITS_W-1:0] e_hits_r;

  always_ff @(posedge clk) begin
    if (pipe_en) begin
      for (int a = 0; a < NUM_AXES; a++) begin
        e_pos_r[a] <= d_pos_r[a];
        e_vel_r[a] <= e_vel_nxt[a];
      end
      e_hits_r <= d_hits_r;
    end
  end

  assign out_valid     = e_valid_r;
  assign out_new_pos_x = e_pos_r[0];
  assign out_new_pos_y = e_pos_r[1];
  assign out_new_pos_z = e_pos_r[2];
  assign out_new_vel_x = e_vel_r[0];
  assign out_new_vel_y = e_vel_r[1];
  assign out_new_vel_z = e_vel_r[2];
  assign out_wall_hits = e_hits_r;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  // an accepted transaction shows up in stage A on the next edge
  `PWB_ASSERT_NEXT(a_in_to_stage_a, in_valid && !in_stall, a_valid_r, "accepted item lost at stage A")
  // a valid item in stage B moves on when the pipeline advances
  `PWB_ASSERT_NEXT(a_stage_b_to_c, b_valid_r && pipe_en, c_valid_r, "item lost between stages B and C")
  // frozen pipeline keeps its middle stages as they were
  `PWB_ASSERT_NEXT(a_freeze_holds, !pipe_en, $stable(c_valid_r) && $stable(d_vel_r[0]), "pipeline moved while frozen")
  // a low-wall hit on x never leaves a positive x velocity positive
  `PWB_ASSERT_NOW(a_reflect_sign, b_valid_r && b_hits_r[0] && (b_vel_r[0] > 0), c_vel_nxt[0] <= 0, "x reflection kept its sign")

endmodule

`default_nettype wire

// ===== verif/particle_wall_bounce_checker.sv =====
// Scoreboard for the particle wall bounce core: watches the config port and both
// channels, predicts each bounce result and compares it field by field.
// Depends on pwb_pkg for widths, reset values and register indexes.
`timescale 1ns / 1ps

module particle_wall_bounce_checker
  import pwb_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_we,
  input  logic [2:0]          cfg_index,
  input  logic [DATA_W-1:0]   cfg_data,
  input  logic                in_valid,
  input  logic                in_stall,
  input  word_t               in_pos_x,
  input  word_t               in_pos_y,
  input  word_t               in_pos_z,
  input  word_t               in_vel_x,
  input  word_t               in_vel_y,
  input  word_t               in_vel_z,
  input  logic [RAD_W-1:0]    in_radius,
  input  logic                out_valid,
  input  logic                out_stall,
  input  word_t               out_new_pos_x,
  input  word_t               out_new_pos_y,
  input  word_t               out_new_pos_z,
  input  word_t               out_new_vel_x,
  input  word_t               out_new_vel_y,
  input  word_t               out_new_vel_z,
  input  logic [HITS_W-1:0]   out_wall_hits,
  output int                  mismatches,
  output int                  outstanding
);

  typedef struct packed {
    logic [DATA_W-1:0] pos_x;
    logic [DATA_W-1:0] pos_y;
    logic [DATA_W-1:0] pos_z;
    logic [DATA_W-1:0] vel_x;
    logic [DATA_W-1:0] vel_y;
    logic [DATA_W-1:0] vel_z;
    logic [HITS_W-1:0] hits;
  } bounce_t;

  // Shadow copy of the wall and restitution registers
  word_t             low_wall [NUM_AXES];
  word_t             high_wall[NUM_AXES];
  logic [REST_W-1:0] gain;

  bounce_t expected_bounces[$];

  // Clamp to the signed 32-bit range
  function automatic word_t clamp_word(input longint v);
    if (v > 64'sd2147483647) begin
      return 32'sh7FFF_FFFF;
    end else if (v < -64'sd2147483648) begin
      return 32'sh8000_0000;
    end
    return v[DATA_W-1:0];
  endfunction

  // -(gain * v), product floored to integer, then clamped
  function automatic word_t reflect_vel(input word_t v);
    longint prod;
    prod = longint'(gain) * longint'(v);
    return clamp_word(-(prod >>> FRAC_BITS));
  endfunction

  // One axis: low wall first, high wall second, both on the incoming position
  function automatic void bounce_axis(input word_t p, input word_t v, input word_t lo,
                                      input word_t hi, input longint r,
                                      output word_t np, output word_t nv,
                                      output logic hit_lo, output logic hit_hi);
    np     = p;
    nv     = v;
    hit_lo = (longint'(p) - r <= longint'(lo));
    hit_hi = (longint'(p) + r >= longint'(hi));
    if (hit_lo) begin
      np = clamp_word(longint'(lo) + r);
      nv = reflect_vel(nv);
    end
    if (hit_hi) begin
      np = clamp_word(longint'(hi) - r);
      nv = reflect_vel(nv);
    end
  endfunction

  function automatic bounce_t predict_bounce(input word_t px, input word_t py,
                                             input word_t pz, input word_t vx,
                                             input word_t vy, input word_t vz,
                                             input logic [RAD_W-1:0] rad);
    word_t             pos_in [NUM_AXES];
    word_t             vel_in [NUM_AXES];
    word_t             pos_out[NUM_AXES];
    word_t             vel_out[NUM_AXES];
    logic [HITS_W-1:0] hits;
    logic              hit_lo;
    logic              hit_hi;
    bounce_t           res;
    pos_in[0] = px;
    pos_in[1] = py;
    pos_in[2] = pz;
    vel_in[0] = vx;
    vel_in[1] = vy;
    vel_in[2] = vz;
    hits = '0;
    for (int a = 0; a < NUM_AXES; a++) begin
      bounce_axis(pos_in[a], vel_in[a], low_wall[a], high_wall[a], longint'(rad),
                  pos_out[a], vel_out[a], hit_lo, hit_hi);
      hits[2*a]   = hit_lo;
      hits[2*a+1] = hit_hi;
    end
    res.pos_x = pos_out[0];
    res.pos_y = pos_out[1];
    res.pos_z = pos_out[2];
    res.vel_x = vel_out[0];
    res.vel_y = vel_out[1];
    res.vel_z = vel_out[2];
    res.hits  = hits;
    return res;
  endfunction

  task automatic check_field(input string name, input logic [DATA_W-1:0] want_v,
                             input logic [DATA_W-1:0] got_v);
    if (got_v !== want_v) begin
      $error("%s mismatch: expected %h, got %h", name, want_v, got_v);
      mismatches++;
    end
  endtask

  // Track config, queue predictions on input transactions, compare on output ones
  always @(posedge clk) begin : monitor
    bounce_t want;
    if (!rst_n) begin
      for (int a = 0; a < NUM_AXES; a++) begin
        low_wall[a]  = LOW_WALL_RST;
        high_wall[a] = HIGH_WALL_RST;
      end
      gain = REST_RST;
      expected_bounces.delete();
      mismatches = 0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_X_LOW_WALL:  low_wall[0]  = cfg_data;
          CFG_X_HIGH_WALL: high_wall[0] = cfg_data;
          CFG_Y_LOW_WALL:  low_wall[1]  = cfg_data;
          CFG_Y_HIGH_WALL: high_wall[1] = cfg_data;
          CFG_Z_LOW_WALL:  low_wall[2]  = cfg_data;
          CFG_Z_HIGH_WALL: high_wall[2] = cfg_data;
          CFG_RESTITUTION: gain         = cfg_data[REST_W-1:0];
          default: ;
        endcase
      end
      if (in_valid && !in_stall) begin
        expected_bounces.push_back(predict_bounce(in_pos_x, in_pos_y, in_pos_z,
                                                  in_vel_x, in_vel_y, in_vel_z,
                                                  in_radius));
      end
      if (out_valid && !out_stall) begin
        if (expected_bounces.size() == 0) begin
          $error("result transaction with no particle pending");
          mismatches++;
        end else begin
          want = expected_bounces.pop_front();
          check_field("new_pos_x", want.pos_x, out_new_pos_x);
          check_field("new_pos_y", want.pos_y, out_new_pos_y);
          check_field("new_pos_z", want.pos_z, out_new_pos_z);
          check_field("new_vel_x", want.vel_x, out_new_vel_x);
          check_field("new_vel_y", want.vel_y, out_new_vel_y);
          check_field("new_vel_z", want.vel_z, out_new_vel_z);
          check_field("wall_hits", DATA_W'(want.hits), DATA_W'(out_wall_hits));
        end
      end
    end
    outstanding <= expected_bounces.size();
  end

endmodule

// ===== verif/particle_wall_bounce_core_test.sv =====
// Testbench top for particle_wall_bounce_core: clock, reset, config phases,
// particle stimulus with bursts and output backpressure, and the verdict.
// Depends on pwb_pkg and particle_wall_bounce_checker.
`timescale 1ns / 1ps

module particle_wall_bounce_core_test;
  import pwb_pkg::*;

  localparam logic [2:0]        CFG_UNUSED     = 3'd7;   // not a register, ignored
  localparam int                NUM_PHASES     = 7;
  localparam int                RAND_PER_PHASE = 300;
  localparam logic [DATA_W-1:0] WMAX           = 32'h7FFF_FFFF;
  localparam logic [DATA_W-1:0] WMIN           = 32'h8000_0000;
  localparam logic [DATA_W-1:0] TEN            = 32'd655360;
  localparam logic [RAD_W-1:0]  RMAX           = '1;

  typedef struct packed {
    logic [DATA_W-1:0] pos_x;
    logic [DATA_W-1:0] pos_y;
    logic [DATA_W-1:0] pos_z;
    logic [DATA_W-1:0] vel_x;
    logic [DATA_W-1:0] vel_y;
    logic [DATA_W-1:0] vel_z;
    logic [RAD_W-1:0]  radius;
  } particle_t;

  logic              clk       = 1'b0;
  logic              rst_n     = 1'b0;
  logic              cfg_we    = 1'b0;
  logic [2:0]        cfg_index = '0;
  logic [DATA_W-1:0] cfg_data  = '0;
  logic              in_valid  = 1'b0;
  logic              in_stall;
  word_t             in_pos_x  = '0;
  word_t             in_pos_y  = '0;
  word_t             in_pos_z  = '0;
  word_t             in_vel_x  = '0;
  word_t             in_vel_y  = '0;
  word_t             in_vel_z  = '0;
  logic [RAD_W-1:0]  in_radius = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  word_t             out_new_pos_x;
  word_t             out_new_pos_y;
  word_t             out_new_pos_z;
  word_t             out_new_vel_x;
  word_t             out_new_vel_y;
  word_t             out_new_vel_z;
  logic [HITS_W-1:0] out_wall_hits;
  int                mismatches;
  int                outstanding;

  // Walls as currently programmed, used to aim particles at them
  word_t             box_lo[NUM_AXES];
  word_t             box_hi[NUM_AXES];
  logic [REST_W-1:0] box_gain;
  int                burst_left;

  particle_wall_bounce_core dut (.*);

  particle_wall_bounce_checker bounce_checker (.*);

  always #6 clk = ~clk;

  // Run limit
  initial begin
    #5_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

  // Output backpressure: quiet, light, medium and heavy stretches, plus long holds
  initial begin : stall_pattern
    int seg_count;
    int pct;
    seg_count = 0;
    do @(posedge clk); while (!rst_n);
    forever begin
      seg_count++;
      if (seg_count % 16 == 3) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(40, 90)) @(posedge clk);
      end else begin
        case ($urandom_range(0, 3))
          0:       pct = 0;
          1:       pct = 20;
          2:       pct = 50;
          default: pct = 80;
        endcase
        repeat ($urandom_range(10, 60)) begin
          out_stall <= ($urandom_range(0, 99) < pct);
          @(posedge clk);
        end
      end
    end
  end

  // Offer one particle; returns at the edge where the transaction is taken
  task automatic offer_particle(input particle_t p);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 40);
    end
    in_pos_x  <= p.pos_x;
    in_pos_y  <= p.pos_y;
    in_pos_z  <= p.pos_z;
    in_vel_x  <= p.vel_x;
    in_vel_y  <= p.vel_y;
    in_vel_z  <= p.vel_z;
    in_radius <= p.radius;
    in_valid  <= 1'b1;
    do @(posedge clk); while (in_stall);
    burst_left--;
  endtask

  // Stop sending, wait for every result, then let the pipeline settle
  task automatic drain_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
    repeat (8) @(posedge clk);
  endtask

  // Write all registers from box_lo/box_hi/box_gain, plus the unused index
  task automatic program_regs();
    logic [DATA_W-1:0] regval[8];
    regval[CFG_X_LOW_WALL]  = box_lo[0];
    regval[CFG_X_HIGH_WALL] = box_hi[0];
    regval[CFG_Y_LOW_WALL]  = box_lo[1];
    regval[CFG_Y_HIGH_WALL] = box_hi[1];
    regval[CFG_Z_LOW_WALL]  = box_lo[2];
    regval[CFG_Z_HIGH_WALL] = box_hi[2];
    regval[CFG_RESTITUTION] = {16'($urandom), box_gain};
    regval[CFG_UNUSED]      = $urandom;
    for (int i = 0; i < 8; i++) begin
      cfg_we    <= 1'b1;
      cfg_index <= 3'(i);
      cfg_data  <= regval[i];
      @(posedge clk);
    end
    cfg_we <= 1'b0;
  endtask

  // Coordinate near the walls, inside the box, far outside, or anything
  function automatic logic [DATA_W-1:0] pick_coord(input int a, input longint r);
    longint lo;
    longint hi;
    longint c;
    lo = longint'(box_lo[a]);
    hi = longint'(box_hi[a]);
    case ($urandom_range(0, 7))
      0: c = longint'($urandom);
      1: c = lo + r + longint'($urandom_range(0, 8)) - 4;
      2: c = hi - r + longint'($urandom_range(0, 8)) - 4;
      3: c = lo - r - longint'($urandom_range(0, 1 << 20));
      4: c = hi + r + longint'($urandom_range(0, 1 << 20));
      default: begin
        if (hi >= lo) begin
          c = lo + (longint'($urandom) % (hi - lo + 1));
        end else begin
          c = hi + longint'($urandom_range(0, 64));
        end
      end
    endcase
    return c[DATA_W-1:0];
  endfunction

  function automatic logic [DATA_W-1:0] pick_vel();
    logic [DATA_W-1:0] v;
    case ($urandom_range(0, 5))
      0, 1: v = $urandom;
      2:    v = 32'(longint'($urandom_range(0, 1 << 18)) - (1 << 17));
      3: begin
        case ($urandom_range(0, 4))
          0:       v = WMIN;
          1:       v = WMAX;
          2:       v = '0;
          3:       v = '1;
          default: v = 32'd1;
        endcase
      end
      default: v = 32'(longint'($urandom_range(0, 8)) - 4);
    endcase
    return v;
  endfunction

  function automatic particle_t rand_particle();
    particle_t         p;
    logic [DATA_W-1:0] pos[NUM_AXES];
    logic [DATA_W-1:0] vel[NUM_AXES];
    case ($urandom_range(0, 9))
      0:       p.radius = 31'($urandom);
      1:       p.radius = $urandom_range(0, 1) ? RMAX : '0;
      default: p.radius = 31'($urandom_range(0, 1 << 20));
    endcase
    for (int a = 0; a < NUM_AXES; a++) begin
      pos[a] = pick_coord(a, longint'(p.radius));
      vel[a] = pick_vel();
    end
    p.pos_x = pos[0];
    p.pos_y = pos[1];
    p.pos_z = pos[2];
    p.vel_x = vel[0];
    p.vel_y = vel[1];
    p.vel_z = vel[2];
    return p;
  endfunction

  initial begin : stimulus
    burst_left = 0;
    box_gain   = REST_RST;
    for (int a = 0; a < NUM_AXES; a++) begin
      box_lo[a] = LOW_WALL_RST;
      box_hi[a] = HIGH_WALL_RST;
    end
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset walls at -10/+10, restitution 1.0
    offer_particle('{32'd0, 32'd0, 32'd0, 32'h0001_0000, 32'hFFFF_0000, 32'd0, 31'h8000});
    // touching the low walls exactly, clamp on -(min velocity)
    offer_particle('{-TEN, -TEN, -TEN, 32'd5, -32'd5, WMIN, 31'd0});
    // touching the high walls exactly
    offer_particle('{TEN, TEN, TEN, WMAX, '1, 32'd1, 31'd0});
    // one LSB inside each wall
    offer_particle('{-TEN + 32'd1, TEN - 32'd1, -TEN + 32'd1, WMIN, WMAX, '1, 31'd0});
    // radius reaches both walls: double reflection
    offer_particle('{32'd0, 32'd0, 32'd0, WMIN, WMAX, 32'h0001_2345, TEN[RAD_W-1:0]});
    offer_particle('{WMIN, WMAX, 32'd0, WMAX, WMIN, '1, RMAX});
    offer_particle('{WMIN, WMAX, 32'd0, 32'd0, 32'd1, WMIN, 31'd3});
    offer_particle('{WMAX, WMIN, 32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555, '1,
                     31'h2AAA_AAAA});
    offer_particle('{32'hAAAA_AAAA, 32'h5555_5555, WMIN, 32'h5555_5555, 32'hAAAA_AAAA,
                     32'd0, 31'h5555_5555});
    offer_particle('{32'h0001_0000, -TEN - 32'd1, TEN + 32'd1, '1, 32'd1, 32'hFFFF_8000,
                     31'd1});

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      if (ph == 1) begin
        // Extreme walls: clamped snaps on x high and z low, y inverted to the limits
        box_lo[0] = WMIN;
        box_hi[0] = 32'h8001_0000;
        box_lo[1] = WMAX;
        box_hi[1] = WMIN;
        box_lo[2] = 32'h7FFF_0000;
        box_hi[2] = WMAX;
        box_gain  = 16'hFFFF;
        program_regs();
        offer_particle('{32'd0, 32'd0, 32'd0, WMAX, WMIN, WMIN, 31'h0002_0000});
        offer_particle('{WMIN, WMAX, WMAX, '1, 32'd1, WMAX, RMAX});
        offer_particle('{WMAX, 32'd0, WMIN, WMIN, 32'd0, 32'd1, 31'd0});
      end else if (ph > 1) begin
        for (int a = 0; a < NUM_AXES; a++) begin
          case (ph)
            3: begin
              // thin or inverted boxes
              box_lo[a] = word_t'($urandom_range(0, 1 << 16)) - 32'sd32768;
              box_hi[a] = box_lo[a] + word_t'($urandom_range(0, 4096)) - 32'sd2048;
            end
            4: begin
              box_lo[a] = $urandom;
              box_hi[a] = $urandom;
            end
            default: begin
              box_lo[a] = -word_t'($urandom_range(1, 1 << 24));
              box_hi[a] = word_t'($urandom_range(1, 1 << 24));
            end
          endcase
        end
        case (ph)
          3:       box_gain = '0;
          5:       box_gain = 16'd1;
          6:       box_gain = REST_RST;
          default: box_gain = 16'($urandom);
        endcase
        program_regs();
      end
      repeat (RAND_PER_PHASE) offer_particle(rand_particle());
      drain_results();
    end

    if (mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
